### hdl/tkac_pkg.sv
package tkac_pkg;

    localparam int MAX_TOP     = 8;
    localparam int MAX_CLASSES = 1024;
    localparam int SCORE_W     = 32;
    localparam int CLASS_W     = 10;
    localparam int TOPK_W      = 4;
    localparam int CNT_W       = 16;
    localparam int FRAC_W      = 17;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [CLASS_W-1:0] CLASS_LAST = CLASS_W'(MAX_CLASSES - 1);
    localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};

    // one finished row handed from front to back
    typedef struct packed {
        logic hit;
        logic batch_end;
    } row_res_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

### hdl/tkac_front.sv
module tkac_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic signed [tkac_pkg::SCORE_W-1:0] score,
    input  logic [tkac_pkg::CLASS_W-1:0]       true_class,
    input  logic                               row_end,
    input  logic                               batch_end,
    input  logic [tkac_pkg::TOPK_W-1:0]        top_k,
    output logic                               push,
    output tkac_pkg::row_res_t                 push_data
);

    logic signed [tkac_pkg::SCORE_W-1:0] sc_reg   [tkac_pkg::MAX_TOP];
    logic [tkac_pkg::CLASS_W-1:0]        cl_reg   [tkac_pkg::MAX_TOP];
    logic [tkac_pkg::MAX_TOP-1:0]        vld_reg;
    logic [tkac_pkg::CLASS_W-1:0]        idx_reg;

    logic signed [tkac_pkg::SCORE_W-1:0] sc_next  [tkac_pkg::MAX_TOP];
    logic [tkac_pkg::CLASS_W-1:0]        cl_next  [tkac_pkg::MAX_TOP];
    logic [tkac_pkg::MAX_TOP-1:0]        vld_next;
    logic [tkac_pkg::MAX_TOP-1:0]        ge;
    logic [tkac_pkg::TOPK_W-1:0]         k_eff;
    logic                                hit;

    // list is sorted with empties at the tail, so ge is a run of ones at the end
    always_comb
    begin
        for (int i = 0; i < tkac_pkg::MAX_TOP; i++)
        begin
            ge[i] = !vld_reg[i] || (sc_reg[i] <= score);
        end
        for (int i = 0; i < tkac_pkg::MAX_TOP; i++)
        begin
            if (ge[i] && (i == 0 || !ge[(i == 0) ? 0 : i - 1]))
            begin
                sc_next[i]  = score;
                cl_next[i]  = idx_reg;
                vld_next[i] = 1'b1;
            end
            else if (ge[i])
            begin
                sc_next[i]  = sc_reg[(i == 0) ? 0 : i - 1];
                cl_next[i]  = cl_reg[(i == 0) ? 0 : i - 1];
                vld_next[i] = vld_reg[(i == 0) ? 0 : i - 1];
            end
            else
            begin
                sc_next[i]  = sc_reg[i];
                cl_next[i]  = cl_reg[i];
                vld_next[i] = vld_reg[i];
            end
        end
        if (top_k == '0)
            k_eff = tkac_pkg::TOPK_W'(1);
        else if (top_k > tkac_pkg::TOPK_W'(tkac_pkg::MAX_TOP))
            k_eff = tkac_pkg::TOPK_W'(tkac_pkg::MAX_TOP);
        else
            k_eff = top_k;
        hit = 1'b0;
        for (int i = 0; i < tkac_pkg::MAX_TOP; i++)
        begin
            if (tkac_pkg::TOPK_W'(i) < k_eff && vld_next[i] && cl_next[i] == true_class)
                hit = 1'b1;
        end
    end

    assign push                = accept && row_end;
    assign push_data.hit       = hit;
    assign push_data.batch_end = batch_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            idx_reg <= '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                vld_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                vld_reg <= vld_next;
                if (idx_reg != tkac_pkg::CLASS_LAST)
                    idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < tkac_pkg::MAX_TOP; i++)
            begin
                sc_reg[i] <= sc_next[i];
                cl_reg[i] <= cl_next[i];
            end
        end
    end

endmodule

### hdl/tkac_fifo.sv
module tkac_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tkac_pkg::row_res_t push_data,
    input  logic               pop,
    output tkac_pkg::row_res_t pop_data,
    output logic               full,
    output logic               empty
);

    tkac_pkg::row_res_t          mem [tkac_pkg::Q_DEPTH];
    logic [tkac_pkg::Q_AW-1:0]   wr_reg;
    logic [tkac_pkg::Q_AW-1:0]   rd_reg;
    logic [tkac_pkg::Q_AW:0]     cnt_reg;

    assign full     = (cnt_reg == (tkac_pkg::Q_AW+1)'(tkac_pkg::Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_data;
    end

endmodule

### hdl/tkac_back.sv
module tkac_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    input  tkac_pkg::row_res_t               pop_data,
    output logic                             pop,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic                             sample_hit,
    output logic [tkac_pkg::CNT_W-1:0]       hit_count,
    output logic [tkac_pkg::CNT_W-1:0]       sample_count,
    output logic [tkac_pkg::FRAC_W-1:0]      accuracy_frac,
    output logic                             batch_done
);

    tkac_pkg::back_state_t state_reg, state_next;

    logic [tkac_pkg::CNT_W-1:0]  hits_reg, samples_reg;
    logic [tkac_pkg::CNT_W-1:0]  h_new, s_new;
    logic [tkac_pkg::CNT_W-1:0]  dh_reg, ds_reg;
    logic                        dhit_reg;
    logic [tkac_pkg::CNT_W-1:0]  rem_reg;
    logic [tkac_pkg::FRAC_W-1:0] quo_reg;
    logic [4:0]                  step_reg;
    logic [tkac_pkg::CNT_W:0]    rem2;
    logic                        out_free;
    logic                        load_plain;
    logic                        load_div;
    logic                        out_valid_reg;

    assign out_free     = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign rem2         = {rem_reg, 1'b0};

    always_comb
    begin
        if (samples_reg != tkac_pkg::CNT_MAX)
        begin
            s_new = samples_reg + 1'b1;
            h_new = hits_reg + tkac_pkg::CNT_W'(pop_data.hit);
        end
        else
        begin
            s_new = samples_reg;
            h_new = hits_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tkac_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_plain = 1'b0;
        load_div   = 1'b0;
        unique case (state_reg)
            tkac_pkg::B_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    if (pop_data.batch_end)
                        state_next = tkac_pkg::B_DIV;
                    else
                        load_plain = 1'b1;
                end
            end
            tkac_pkg::B_DIV:
            begin
                if (step_reg == 5'd16)
                    state_next = tkac_pkg::B_OUT;
            end
            tkac_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    load_div   = 1'b1;
                    state_next = tkac_pkg::B_IDLE;
                end
            end
            default: state_next = tkac_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg      <= '0;
            samples_reg   <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (pop)
            begin
                hits_reg    <= pop_data.batch_end ? '0 : h_new;
                samples_reg <= pop_data.batch_end ? '0 : s_new;
            end
            if (load_plain || load_div)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
            if (pop)
                step_reg <= '0;
            else if (state_reg == tkac_pkg::B_DIV)
                step_reg <= step_reg + 1'b1;
        end
    end

    // restoring division of hits*2^16 by samples, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dh_reg   <= h_new;
            ds_reg   <= s_new;
            dhit_reg <= pop_data.hit;
        end
        if (state_reg == tkac_pkg::B_DIV)
        begin
            if (step_reg == '0)
            begin
                // hits never exceeds samples, so the top bit is a plain compare
                if (dh_reg >= ds_reg)
                begin
                    quo_reg <= tkac_pkg::FRAC_W'(1);
                    rem_reg <= dh_reg - ds_reg;
                end
                else
                begin
                    quo_reg <= '0;
                    rem_reg <= dh_reg;
                end
            end
            else if (rem2 >= {1'b0, ds_reg})
            begin
                quo_reg <= {quo_reg[tkac_pkg::FRAC_W-2:0], 1'b1};
                rem_reg <= tkac_pkg::CNT_W'(rem2 - {1'b0, ds_reg});
            end
            else
            begin
                quo_reg <= {quo_reg[tkac_pkg::FRAC_W-2:0], 1'b0};
                rem_reg <= rem2[tkac_pkg::CNT_W-1:0];
            end
        end
        if (load_plain)
        begin
            sample_hit    <= pop_data.hit;
            hit_count     <= h_new;
            sample_count  <= s_new;
            accuracy_frac <= '0;
            batch_done    <= 1'b0;
        end
        else if (load_div)
        begin
            sample_hit    <= dhit_reg;
            hit_count     <= dh_reg;
            sample_count  <= ds_reg;
            accuracy_frac <= quo_reg;
            batch_done    <= 1'b1;
        end
    end

    a_hits_le_samples: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= samples_reg)
        else $error("hit counter ran ahead of sample counter");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(hit_count))
        else $error("stalled result lost");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == tkac_pkg::B_IDLE && !empty)
        else $error("queue popped while back end busy");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load_div |-> quo_reg <= tkac_pkg::FRAC_W'(65536))
        else $error("accuracy fraction out of range");

endmodule

### hdl/top_k_accuracy_counter_core.sv
// top-k accuracy counter
// item channel: item_valid/item_stall carry one class score per request,
// with true_class, row_end and batch_end; class indices count up from 0
// within a row. result channel: result_valid/result_stall, one result per
// row, issued after the row's last score.
// cfg channel: cfg_valid/cfg_ready writes top_k (always ready); write only
// when idle.
// the front end takes one score per cycle while the queue is not full
// and keeps the sorted list of the best pairs; a finished row goes into
// a 4-entry queue. the back end updates the hit and sample counters. an
// ordinary row's result is registered from the queue; a batch-closing row
// first passes the bit-serial divider (one quotient bit a cycle).
// sustained rate is one score per cycle, unless rows close faster than the
// back end drains them, when item_stall rises as the queue fills.
// while result_stall holds back a valid result, the result register holds,
// the back end waits and the queue absorbs further rows.
// reset clears the list, class counter, counters and queue; top_k resets to 1.
module top_k_accuracy_counter_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic signed [tkac_pkg::SCORE_W-1:0] score,
    input  logic [tkac_pkg::CLASS_W-1:0]        true_class,
    input  logic                                row_end,
    input  logic                                batch_end,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkac_pkg::TOPK_W-1:0]         top_k,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                sample_hit,
    output logic [tkac_pkg::CNT_W-1:0]          hit_count,
    output logic [tkac_pkg::CNT_W-1:0]          sample_count,
    output logic [tkac_pkg::FRAC_W-1:0]         accuracy_frac,
    output logic                                batch_done
);

    logic [tkac_pkg::TOPK_W-1:0] top_k_reg;
    logic                        accept, push, pop, full, empty;
    tkac_pkg::row_res_t          push_data, pop_data;

    assign cfg_ready  = 1'b1;
    assign item_stall = full;
    assign accept     = item_valid && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_k_reg <= tkac_pkg::TOPK_W'(1);
        else if (cfg_valid)
            top_k_reg <= top_k;
    end

    tkac_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .score      (score),
        .true_class (true_class),
        .row_end    (row_end),
        .batch_end  (batch_end),
        .top_k      (top_k_reg),
        .push       (push),
        .push_data  (push_data)
    );

    tkac_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    tkac_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .pop_data      (pop_data),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample_hit    (sample_hit),
        .hit_count     (hit_count),
        .sample_count  (sample_count),
        .accuracy_frac (accuracy_frac),
        .batch_done    (batch_done)
    );

endmodule

### tb/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_TOP = tkac_pkg::MAX_TOP;
    localparam int SCORE_W = tkac_pkg::SCORE_W;
    localparam int CLASS_W = tkac_pkg::CLASS_W;
    localparam int TOPK_W  = tkac_pkg::TOPK_W;
    localparam int CNT_W   = tkac_pkg::CNT_W;
    localparam int FRAC_W  = tkac_pkg::FRAC_W;
    localparam logic [CLASS_W-1:0] CLASS_LAST = tkac_pkg::CLASS_LAST;
    localparam logic [CNT_W-1:0]   CNT_MAX    = tkac_pkg::CNT_MAX;

    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam int     DRAIN_WAIT  = 40;

    typedef struct {
        logic              hit;
        logic [CNT_W-1:0]  hits;
        logic [CNT_W-1:0]  samples;
        logic [FRAC_W-1:0] frac;
        logic              done;
    } acc_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic signed [SCORE_W-1:0]  score = '0;
    logic [CLASS_W-1:0]         true_class = '0;
    logic                       row_end = 1'b0;
    logic                       batch_end = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [TOPK_W-1:0]          top_k = TOPK_W'(1);
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic                       sample_hit;
    logic [CNT_W-1:0]           hit_count;
    logic [CNT_W-1:0]           sample_count;
    logic [FRAC_W-1:0]          accuracy_frac;
    logic                       batch_done;

    // predictor state
    logic signed [SCORE_W-1:0]  rank_score [MAX_TOP];
    logic [CLASS_W-1:0]         rank_class [MAX_TOP];
    logic                       rank_vld   [MAX_TOP];
    logic [CLASS_W-1:0]         class_idx;
    logic [CNT_W-1:0]           hit_tally;
    logic [CNT_W-1:0]           sample_tally;
    logic [TOPK_W-1:0]          k_setting;

    acc_result_t pending_results[$];
    int          errors = 0;
    int          send_gap_pct = 0;
    int          rx_stall_pct = 0;
    longint      cycles = 0;

    top_k_accuracy_counter_core dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall),
        .score(score), .true_class(true_class), .row_end(row_end), .batch_end(batch_end),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .top_k(top_k),
        .result_valid(result_valid), .result_stall(result_stall),
        .sample_hit(sample_hit), .hit_count(hit_count), .sample_count(sample_count),
        .accuracy_frac(accuracy_frac), .batch_done(batch_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_ranking();
        for (int i = 0; i < MAX_TOP; i++)
        begin
            rank_score[i] = '0;
            rank_class[i] = '0;
            rank_vld[i]   = 1'b0;
        end
        class_idx = '0;
    endfunction

    function automatic void predict_score(logic signed [SCORE_W-1:0] s, logic [CLASS_W-1:0] lbl,
                                          logic re, logic be);
        int          pos;
        int          k;
        logic        hit;
        longint      q;
        acc_result_t r;
        pos = -1;
        hit = 1'b0;
        for (int i = 0; i < MAX_TOP; i++)
            if (pos < 0 && (!rank_vld[i] || rank_score[i] <= s))
                pos = i;
        if (pos >= 0)
        begin
            for (int i = MAX_TOP - 1; i > pos; i--)
            begin
                rank_score[i] = rank_score[i-1];
                rank_class[i] = rank_class[i-1];
                rank_vld[i]   = rank_vld[i-1];
            end
            rank_score[pos] = s;
            rank_class[pos] = class_idx;
            rank_vld[pos]   = 1'b1;
        end
        if (class_idx != CLASS_LAST)
            class_idx++;
        if (re)
        begin
            k = (k_setting == 0) ? 1 : (k_setting > MAX_TOP) ? MAX_TOP : int'(k_setting);
            for (int i = 0; i < k; i++)
                if (rank_vld[i] && rank_class[i] == lbl)
                    hit = 1'b1;
            if (sample_tally != CNT_MAX)
            begin
                sample_tally++;
                if (hit)
                    hit_tally++;
            end
            q = 0;
            if (be && sample_tally != 0)
                q = (longint'(hit_tally) << 16) / longint'(sample_tally);
            r.hit     = hit;
            r.hits    = hit_tally;
            r.samples = sample_tally;
            r.frac    = be ? FRAC_W'(q) : '0;
            r.done    = be;
            pending_results = {pending_results, r};
            clear_ranking();
            if (be)
            begin
                hit_tally    = '0;
                sample_tally = '0;
            end
        end
    endfunction

    // one score request; the caller lowers item_valid once the burst is over
    task automatic send_score(logic signed [SCORE_W-1:0] s, logic [CLASS_W-1:0] lbl,
                              logic re, logic be);
        if ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        item_valid <= 1'b1;
        score      <= s;
        true_class <= lbl;
        row_end    <= re;
        batch_end  <= be;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_score(s, lbl, re, be);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_top_k(logic [TOPK_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        top_k     <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        k_setting = v;
    endtask

    function automatic logic signed [SCORE_W-1:0] rand_score();
        unique case ($urandom_range(3))
            0: return SCORE_W'($urandom_range(4));        // many ties
            1: return -SCORE_W'($urandom_range(4));
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        write_top_k(TOPK_W'(1));
        // extremes, the larger index wins a tie
        send_score(32'sh7fffffff, 10'd0, 1'b0, 1'b0);
        send_score(32'sh80000000, 10'd0, 1'b0, 1'b0);
        send_score(32'sh7fffffff, 10'd1, 1'b0, 1'b1);  // batch_end without row_end
        send_score(32'sh00000000, 10'd2, 1'b1, 1'b0);
        send_score(32'sh00000000, 10'd0, 1'b1, 1'b0);  // row of one, hit
        send_score(-32'sd5, 10'h3ff, 1'b1, 1'b0);      // miss
        send_score(32'sh80000000, 10'd0, 1'b1, 1'b1);  // closes the batch
        write_top_k(TOPK_W'(8));
        // short row: label on an unfilled slot must miss
        send_score(32'sd3, 10'd0, 1'b0, 1'b0);
        send_score(32'sd4, 10'd5, 1'b1, 1'b0);
        send_score(32'sd1, 10'd0, 1'b0, 1'b0);
        send_score(32'sd1, 10'd0, 1'b0, 1'b0);
        send_score(32'sd1, 10'd0, 1'b1, 1'b1);
        send_score(32'sd9, 10'd1, 1'b1, 1'b1);         // batch of one, miss
    endtask

    task automatic run_rows(int n_items);
        int sent;
        int len;
        int rows_left;
        sent = 0;
        rows_left = $urandom_range(1, 6);
        while (sent < n_items)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                logic re;
                logic [CLASS_W-1:0] lbl;
                re  = (i == len - 1);
                lbl = ($urandom_range(4) == 0) ? CLASS_W'($urandom()) : CLASS_W'($urandom_range(len));
                send_score(rand_score(), lbl, re,
                           re ? (rows_left == 1) : ($urandom_range(7) == 0));
            end
            sent += len;
            rows_left--;
            if (rows_left == 0)
                rows_left = $urandom_range(1, 6);
        end
        // close the open batch
        send_score(rand_score(), CLASS_W'($urandom()), 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic();
        send_gap_pct = 8;
        rx_stall_pct = 68;
        write_top_k(TOPK_W'(0));
        run_rows(60);
        write_top_k(TOPK_W'(15));
        run_rows(60);
        write_top_k(TOPK_W'($urandom_range(1, 8)));
        run_rows(100);
        send_gap_pct = 68;
        rx_stall_pct = 8;
        write_top_k(TOPK_W'($urandom_range(0, 15)));
        run_rows(100);
        write_top_k(TOPK_W'(2));
        run_rows(80);
        send_gap_pct = 0;
        rx_stall_pct = 0;
        write_top_k(TOPK_W'($urandom_range(1, 8)));
        run_rows(100);
        write_top_k(TOPK_W'(8));
        run_rows(100);
    endtask

    initial
    begin
        clear_ranking();
        hit_tally    = '0;
        sample_tally = '0;
        k_setting    = TOPK_W'(1);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        result_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk)
    begin
        acc_result_t r;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b hits=%0d samples=%0d",
                         $time, sample_hit, hit_count, sample_count);
                errors++;
            end
            else
            begin
                r = pending_results.pop_front();
                if (sample_hit !== r.hit)
                begin
                    $display("%0t: sample_hit exp %0b got %0b", $time, r.hit, sample_hit);
                    errors++;
                end
                if (hit_count !== r.hits)
                begin
                    $display("%0t: hit_count exp %0d got %0d", $time, r.hits, hit_count);
                    errors++;
                end
                if (sample_count !== r.samples)
                begin
                    $display("%0t: sample_count exp %0d got %0d", $time, r.samples, sample_count);
                    errors++;
                end
                if (accuracy_frac !== r.frac)
                begin
                    $display("%0t: accuracy_frac exp %0d got %0d", $time, r.frac, accuracy_frac);
                    errors++;
                end
                if (batch_done !== r.done)
                begin
                    $display("%0t: batch_done exp %0b got %0b", $time, r.done, batch_done);
                    errors++;
                end
            end
        end
    end

endmodule
